// ----- rtl/core/ttsb_pkg.sv -----
// text terminal scrollback: shared constants and codes
// no dependencies; used by the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package ttsb_pkg;

    // default geometry
    localparam int DEF_COLUMNS     = 80;
    localparam int DEF_SCREEN_ROWS = 25;
    localparam int DEF_BUFFER_ROWS = 50;

    // operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // character codes
    localparam logic [7:0] LF_CODE         = 8'd10;
    localparam logic [7:0] SPACE_CODE      = 8'd32;
    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0] DEL_CODE        = 8'd127;

    // colors
    localparam logic [3:0] ATTR_BLACK      = 4'd0;
    localparam logic [3:0] ATTR_LIGHT_GREY = 4'd7;

    // blank cell written by a line feed: space, light grey on black
    localparam logic [15:0] BLANK_CELL = {ATTR_BLACK, ATTR_LIGHT_GREY, SPACE_CODE};

    // attribute register after reset
    localparam logic [7:0] COLOR_RESET = {ATTR_BLACK, ATTR_LIGHT_GREY};

endpackage

`default_nettype wire

// ----- rtl/core/ttsb_cell_mem.sv -----
// text terminal scrollback: single-port cell memory, registered read data
// no package dependencies; instantiated by text_terminal_scrollback
`timescale 1ns / 1ps
`default_nettype none

module ttsb_cell_mem #(
    parameter int DEPTH = 4000,
    parameter int AW    = 12
) (
    input  wire  logic          i_clk,
    input  wire  logic          i_en,
    input  wire  logic          i_we,
    input  wire  logic [AW-1:0] i_addr,
    input  wire  logic [15:0]   i_wdata,
    output logic [15:0]         o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    // one access per cycle: write, or read with registered read data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/text_terminal_scrollback.sv -----
// text terminal scrollback: top level, control sequencer around the cell memory
// depends on ttsb_pkg and ttsb_cell_mem
//
//   channel   direction   handshake             payload
//   input     in          i_valid / o_stall     i_opcode i_char_code i_screen_row i_screen_column
//   output    out         o_valid / i_stall     o_cell_word o_cursor_column o_cursor_screen_row
//   config    in          i_cfg_we              i_cfg_data
//
// put of a printable code: a single memory write; another code moves the column without a write
// line feed, or a put on the last column: the new row is blanked, one cell of it per cycle
// read: ST_RD_MOD takes BUFFER_ROWS off the row sum until it lies in the buffer, then ST_RD_WAIT
// loads the result into the output register once it is free, and the result waits there until taken
// after reset a clearing pass writes zeros to all BUFFER_ROWS * COLUMNS cells (4000 by default)
// with o_stall high; configuration writes are taken during the pass
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_scrollback #(
    parameter int COLUMNS     = ttsb_pkg::DEF_COLUMNS,
    parameter int SCREEN_ROWS = ttsb_pkg::DEF_SCREEN_ROWS,
    parameter int BUFFER_ROWS = ttsb_pkg::DEF_BUFFER_ROWS
) (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    // configuration
    input  wire  logic        i_cfg_we,
    input  wire  logic [7:0]  i_cfg_data,
    // input channel
    input  wire  logic        i_valid,
    output logic              o_stall,
    input  wire  logic        i_opcode,
    input  wire  logic [7:0]  i_char_code,
    input  wire  logic [4:0]  i_screen_row,
    input  wire  logic [6:0]  i_screen_column,
    // output channel
    output logic              o_valid,
    input  wire  logic        i_stall,
    output logic [15:0]       o_cell_word,
    output logic [6:0]        o_cursor_column,
    output logic [4:0]        o_cursor_screen_row
);

    localparam int CELLS = BUFFER_ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(BUFFER_ROWS);
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int VW    = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int SW    = (RW > 5) ? RW + 1 : 6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_RD_MOD,
        ST_RD_WAIT
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_clr_addr;
    logic [RW-1:0]   r_abs_row;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_scroll;
    logic [VW-1:0]   r_vis_row;
    logic [CW-1:0]   r_fill_col;
    logic [7:0]      r_color;
    logic [SW-1:0]   r_row_sum;
    logic [6:0]      r_rd_col;
    logic            r_rd_oor;
    logic            r_out_valid;
    logic [15:0]     r_cell_word;
    logic [6:0]      r_cur_col;
    logic [4:0]      r_cur_row;

    logic            in_xfer;
    logic            is_lf;
    logic            is_print;
    logic            at_last_col;
    logic            out_free;
    logic            sum_wraps;
    logic [RW-1:0]   n_abs_row;
    logic [RW-1:0]   n_scroll;
    logic            mem_en;
    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    logic [15:0]     mem_wdata;
    logic [15:0]     mem_rdata;
    logic [AW-1:0]   rd_col_addr;

    // input decode
    assign in_xfer     = i_valid && (r_state == ST_IDLE);
    assign is_lf       = (i_char_code == ttsb_pkg::LF_CODE);
    assign is_print    = (i_char_code >= ttsb_pkg::FIRST_PRINTABLE) &&
                         (i_char_code < ttsb_pkg::DEL_CODE);
    assign at_last_col = (r_col == CW'(COLUMNS - 1));
    assign out_free    = !r_out_valid || !i_stall;
    assign sum_wraps   = (r_row_sum >= SW'(BUFFER_ROWS));

    // next row and scroll position for a line feed
    assign n_abs_row = (r_abs_row == RW'(BUFFER_ROWS - 1)) ? '0 : r_abs_row + 1'b1;
    assign n_scroll  = (r_scroll == RW'(BUFFER_ROWS - 1)) ? '0 : r_scroll + 1'b1;

    // column of a read, kept inside the row when out of range
    assign rd_col_addr = r_rd_oor ? '0 : AW'(r_rd_col);

    // memory port select
    always_comb begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
            end
            ST_FILL: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = AW'(r_abs_row) * AW'(COLUMNS) + AW'(r_fill_col);
                mem_wdata = ttsb_pkg::BLANK_CELL;
            end
            ST_IDLE: begin
                if (in_xfer && (i_opcode == ttsb_pkg::OP_PUT) && is_print) begin
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_addr  = AW'(r_abs_row) * AW'(COLUMNS) + AW'(r_col);
                    mem_wdata = {r_color, i_char_code};
                end
            end
            ST_RD_MOD: begin
                if (!sum_wraps) begin
                    mem_en   = 1'b1;
                    mem_addr = AW'(r_row_sum) * AW'(COLUMNS) + rd_col_addr;
                end
            end
            ST_RD_WAIT: begin
                mem_en = 1'b0;
            end
            default: begin
                mem_en = 1'b0;
            end
        endcase
    end

    ttsb_cell_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_cell_mem (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // sequencer, cursor state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_abs_row   <= '0;
            r_col       <= '0;
            r_scroll    <= '0;
            r_vis_row   <= '0;
            r_fill_col  <= '0;
            r_color     <= ttsb_pkg::COLOR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_color <= i_cfg_data;
            end

            // output transfer frees the register, unless a new result loads it
            if (r_out_valid && !i_stall && (r_state != ST_RD_WAIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(CELLS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (i_opcode == ttsb_pkg::OP_PUT) begin
                            if (is_lf || at_last_col) begin
                                // line feed or a put on the last column: move to the next row and blank it
                                r_abs_row  <= n_abs_row;
                                r_col      <= '0;
                                r_fill_col <= '0;
                                if (32'(r_vis_row) + 1 < SCREEN_ROWS) begin
                                    r_vis_row <= r_vis_row + 1'b1;
                                end else begin
                                    r_scroll <= n_scroll;
                                end
                                r_state <= ST_FILL;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end else begin
                            r_row_sum <= SW'(r_scroll) + SW'(i_screen_row);
                            r_rd_col  <= i_screen_column;
                            r_rd_oor  <= (32'(i_screen_row) >= SCREEN_ROWS) ||
                                         (32'(i_screen_column) >= COLUMNS);
                            r_state   <= ST_RD_MOD;
                        end
                    end
                end
                ST_FILL: begin
                    r_fill_col <= r_fill_col + 1'b1;
                    if (r_fill_col == CW'(COLUMNS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_RD_MOD: begin
                    // one wrap of the buffer per cycle
                    if (sum_wraps) begin
                        r_row_sum <= r_row_sum - SW'(BUFFER_ROWS);
                    end else begin
                        r_state <= ST_RD_WAIT;
                    end
                end
                ST_RD_WAIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_cell_word <= r_rd_oor ? '0 : mem_rdata;
                        r_cur_col   <= 7'(r_col);
                        r_cur_row   <= 5'(r_vis_row);
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall             = (r_state != ST_IDLE);
    assign o_valid             = r_out_valid;
    assign o_cell_word         = r_cell_word;
    assign o_cursor_column     = r_cur_col;
    assign o_cursor_screen_row = r_cur_row;

endmodule

`default_nettype wire

// ----- rtl/core/ttsb_checker.sv -----
// text terminal scrollback: port-level checker and its bind to the top level
// depends on ttsb_pkg; attaches to text_terminal_scrollback
`timescale 1ns / 1ps
`default_nettype none

module ttsb_checker #(
    parameter int COLUMNS     = ttsb_pkg::DEF_COLUMNS,
    parameter int SCREEN_ROWS = ttsb_pkg::DEF_SCREEN_ROWS
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        i_opcode,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_cell_word,
    input wire logic [6:0]  o_cursor_column,
    input wire logic [4:0]  o_cursor_screen_row
);

    // reset empties the output and starts the clearing pass
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_stall))
        else $error("output valid or input open right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_cell_word) &&
                                  $stable(o_cursor_column) && $stable(o_cursor_screen_row)))
        else $error("stalled result changed");

    // a put transfer never produces a result
    a_put_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_opcode == ttsb_pkg::OP_PUT) && !o_valid) |=> !o_valid)
        else $error("result after a put");

    // a read transfer keeps the input side stalled behind it
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_opcode == ttsb_pkg::OP_READ)) |=> o_stall)
        else $error("input reopened in the cycle after a read");

    // reported cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((32'(o_cursor_column) < COLUMNS) &&
                     (32'(o_cursor_screen_row) < SCREEN_ROWS)))
        else $error("cursor outside the screen");

endmodule

bind text_terminal_scrollback ttsb_checker #(
    .COLUMNS     (COLUMNS),
    .SCREEN_ROWS (SCREEN_ROWS)
) u_ttsb_checker (.*);

`default_nettype wire
